// ===== rtl/nearest_palette_color_search_top_macros.svh =====
// assertion macros for the nearest palette color search block
`ifndef NEAREST_PALETTE_COLOR_SEARCH_TOP_MACROS_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while in reset
`define NPCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("npcs assertion failed");

// next-cycle implication, disabled while in reset
`define NPCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("npcs assertion failed");

`else

`define NPCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define NPCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/npcs_pkg.sv =====
package npcs_pkg;

    // palette geometry
    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W         = $clog2(PALETTE_DEPTH);
    localparam int SIZE_W        = 9;
    localparam int CH_W          = 8;
    localparam int SQ_W          = 2 * CH_W;
    localparam int WT_W          = 10;
    localparam int TERM_W        = 18;
    localparam int DIST_W        = 20;

    // redmean weights
    localparam int WEIGHT_R_BASE = 512;
    localparam int WEIGHT_B_BASE = 767;
    localparam int MAX_DIST      = 649726;

    // item action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic            action;
        logic [7:0]      entry_index;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        best_index;
        logic [DIST_W-1:0] nearest_dist;
        logic              empty_error;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic             mem_we;
        logic             load_query;
        logic             issue;
        logic             issue_first;
        logic [IDX_W-1:0] addr;
        logic             report;
        logic             empty;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;
    } t_dp_status;

endpackage

// ===== rtl/npcs_ctrl.sv =====
module npcs_ctrl
    import npcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_action,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    input  t_dp_status        i_status,
    output t_dp_cmd           o_cmd,
    output logic              o_busy,
    output logic              o_done
);

    t_state             r_state, n_state;
    logic [SIZE_W-1:0]  r_size;
    logic [IDX_W-1:0]   r_addr, n_addr;
    logic [IDX_W-1:0]   r_last, n_last;
    logic               r_empty, n_empty;
    logic [SIZE_W-1:0]  size_m1;
    logic [IDX_W-1:0]   sat_last;

    // palette size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
        end
    end

    // last entry to visit, saturated at the palette depth
    assign size_m1  = r_size - SIZE_W'(1);
    assign sat_last = (r_size > SIZE_W'(PALETTE_DEPTH)) ? IDX_W'(PALETTE_DEPTH - 1)
                                                         : size_m1[IDX_W-1:0];

    // state and sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_addr  <= '0;
            r_last  <= '0;
            r_empty <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_last  <= n_last;
            r_empty <= n_empty;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_last  = r_last;
        n_empty = r_empty;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_action == ACT_QUERY) begin
                        o_cmd.load_query = 1'b1;
                        n_addr           = '0;
                        n_last           = sat_last;
                        if (r_size == '0) begin
                            n_empty = 1'b1;
                            n_state = ST_DONE;
                        end else begin
                            n_empty = 1'b0;
                            n_state = ST_RUN;
                        end
                    end else begin
                        o_cmd.mem_we = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                o_cmd.issue       = 1'b1;
                o_cmd.addr        = r_addr;
                o_cmd.issue_first = (r_addr == '0);
                if (r_addr == r_last) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_cmd.report = 1'b1;
                o_cmd.empty  = r_empty;
                n_empty      = 1'b0;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_DONE);

endmodule

// ===== rtl/npcs_datapath.sv =====
module npcs_datapath
    import npcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_item,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_item  o_result
);

    logic [3*CH_W-1:0] mem [PALETTE_DEPTH];

    // query color
    logic [CH_W-1:0]   r_qr, r_qg, r_qb;

    // stage 1: palette read
    logic              r_v1, r_f1;
    logic [IDX_W-1:0]  r_i1;
    logic [3*CH_W-1:0] r_rd_data;

    // stage 2: squares and weights
    logic              r_v2, r_f2;
    logic [IDX_W-1:0]  r_i2;
    logic [SQ_W-1:0]   r_sq_r, r_sq_g, r_sq_b;
    logic [WT_W-1:0]   r_w_r, r_w_b;

    // stage 3: weighted terms
    logic              r_v3, r_f3;
    logic [IDX_W-1:0]  r_i3;
    logic [TERM_W-1:0] r_tr, r_tg, r_tb;

    // stage 4: distance
    logic              r_v4, r_f4;
    logic [IDX_W-1:0]  r_i4;
    logic [DIST_W-1:0] r_dist;

    // running best
    logic [IDX_W-1:0]  r_best_idx;
    logic [DIST_W-1:0] r_best_dist;

    logic [CH_W-1:0]   pr, pg, pb;
    logic [CH_W-1:0]   dr, dg, db;
    logic [CH_W:0]     rsum;
    logic [CH_W-1:0]   rmean;
    logic [SQ_W+WT_W-1:0] prod_r, prod_b;

    // palette memory, written by write items, read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            mem[i_item.entry_index[IDX_W-1:0]] <= {i_item.red, i_item.green, i_item.blue};
        end
        if (i_cmd.issue) begin
            r_rd_data <= mem[i_cmd.addr];
        end
    end

    // query color capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_qr <= i_item.red;
            r_qg <= i_item.green;
            r_qb <= i_item.blue;
        end
    end

    // valid flags down the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // component differences and red mean
    assign pr    = r_rd_data[3*CH_W-1:2*CH_W];
    assign pg    = r_rd_data[2*CH_W-1:CH_W];
    assign pb    = r_rd_data[CH_W-1:0];
    assign dr    = (pr >= r_qr) ? pr - r_qr : r_qr - pr;
    assign dg    = (pg >= r_qg) ? pg - r_qg : r_qg - pg;
    assign db    = (pb >= r_qb) ? pb - r_qb : r_qb - pb;
    assign rsum  = {1'b0, pr} + {1'b0, r_qr};
    assign rmean = rsum[CH_W:1];

    // weighted products
    assign prod_r = r_w_r * r_sq_r;
    assign prod_b = r_w_b * r_sq_b;

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_f1   <= i_cmd.issue_first;
        r_i1   <= i_cmd.addr;

        r_f2   <= r_f1;
        r_i2   <= r_i1;
        r_sq_r <= dr * dr;
        r_sq_g <= dg * dg;
        r_sq_b <= db * db;
        r_w_r  <= WT_W'(WEIGHT_R_BASE) + WT_W'(rmean);
        r_w_b  <= WT_W'(WEIGHT_B_BASE) - WT_W'(rmean);

        r_f3   <= r_f2;
        r_i3   <= r_i2;
        r_tr   <= prod_r[SQ_W+WT_W-1:8];
        r_tg   <= {r_sq_g, 2'b00};
        r_tb   <= prod_b[SQ_W+WT_W-1:8];

        r_f4   <= r_f3;
        r_i4   <= r_i3;
        r_dist <= DIST_W'(r_tr) + DIST_W'(r_tg) + DIST_W'(r_tb);
    end

    // keep the nearest entry, lowest index wins on ties
    always_ff @(posedge i_clk) begin
        if (r_v4 && (r_f4 || (r_dist < r_best_dist))) begin
            r_best_idx  <= r_i4;
            r_best_dist <= r_dist;
        end
    end

    assign o_status.pipe_busy = r_v1 | r_v2 | r_v3 | r_v4;

    // result fields
    always_comb begin
        o_result = '0;
        if (i_cmd.report) begin
            if (i_cmd.empty) begin
                o_result.empty_error = 1'b1;
            end else begin
                o_result.best_index   = 8'(r_best_idx);
                o_result.nearest_dist = r_best_dist;
            end
        end
    end

endmodule

// ===== rtl/nearest_palette_color_search_top.sv =====
// nearest palette color search, redmean metric
//
// items enter on i_item when start is high and busy is low. a write item
// (action 0) stores red/green/blue at entry_index in the palette memory in
// that same cycle and gives no result; busy stays low, so items may follow
// back to back. a query item (action 1) walks entries 0 to palette_size-1,
// one memory read per cycle, through a four stage distance pipe.
// the result comes on o_result with o_done high for exactly one cycle;
// the receiver cannot stall it and must take it then.
// a query's result waits on the one-entry-per-cycle walk over the memory
// read port across n entries, n being palette_size saturated at the memory
// depth, then on the pipe depth and the best-entry update; busy is high
// over that whole span, so queries run one at a time and the next item is
// taken only once busy falls.
// an empty palette gives empty_error in the cycle after accept.
// palette_size is written with i_cfg_we / i_cfg_wdata; the user must write
// it only while idle, as the block does not enforce this. reset clears
// palette_size to zero and the controller to idle; palette entries are
// undefined until written and must be written before a query reaches them.
`include "nearest_palette_color_search_top_macros.svh"

module nearest_palette_color_search_top
    import npcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in_item          i_item,
    output logic              o_done,
    output t_out_item         o_result,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencer
    npcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_action    (i_item.action),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_done      (o_done)
    );

    // memory and distance pipe
    npcs_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (o_result)
    );

    // result strobe lasts one cycle and only while busy
    `NPCS_ASSERT_NXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `NPCS_ASSERT_IMP(a_done_busy, i_clk, i_rst_n, o_done, busy)
    // an accepted query keeps the block busy
    `NPCS_ASSERT_NXT(a_query_busy, i_clk, i_rst_n,
                     start && !busy && (i_item.action == ACT_QUERY), busy)
    // empty palette results carry zero fields, others stay within range
    `NPCS_ASSERT_IMP(a_result_fields, i_clk, i_rst_n, o_done,
                     (o_result.empty_error && (o_result.best_index == '0)
                      && (o_result.nearest_dist == '0))
                     || (!o_result.empty_error
                         && (o_result.nearest_dist <= DIST_W'(MAX_DIST))))

endmodule
